### hdl/ic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ic_pkg - shared types and helpers for the intcode processor
// Word kinds, opcodes, mode codes, controller/datapath command and status
// structs, and the decimal digit helpers used by the instruction decoder.
// ----------------------------------------------------------------------------
package ic_pkg;

  localparam int unsigned MemWordsDef = 4096;
  localparam int unsigned StepLimit   = 1048576;
  localparam int          StepW       = $clog2(StepLimit) + 1;
  localparam int          DecSteps    = 16;
  localparam int          DecCntW     = $clog2(DecSteps);

  localparam logic [16:0] Mod100  = 17'd100;
  localparam logic [16:0] Mod1k   = 17'd1000;
  localparam logic [16:0] Mod10k  = 17'd10000;
  localparam logic [16:0] Mod100k = 17'd100000;

  localparam logic [6:0] OpAdd  = 7'd1;
  localparam logic [6:0] OpMul  = 7'd2;
  localparam logic [6:0] OpIn   = 7'd3;
  localparam logic [6:0] OpOut  = 7'd4;
  localparam logic [6:0] OpJnz  = 7'd5;
  localparam logic [6:0] OpJz   = 7'd6;
  localparam logic [6:0] OpLt   = 7'd7;
  localparam logic [6:0] OpEq   = 7'd8;
  localparam logic [6:0] OpArb  = 7'd9;
  localparam logic [6:0] OpHalt = 7'd99;

  localparam logic [3:0] ModePos = 4'd0;
  localparam logic [3:0] ModeImm = 4'd1;
  localparam logic [3:0] ModeRel = 4'd2;

  typedef enum logic [2:0] {
    KIND_OUT  = 3'd0,
    KIND_NEED = 3'd1,
    KIND_HALT = 3'd2,
    KIND_ERR  = 3'd3,
    KIND_LOAD = 3'd4
  } kind_e;

  typedef struct packed {
    logic  clr_step;
    logic  load_wr;
    logic  run_start;
    logic  fetch;
    logic  dec_start;
    logic  dec_step;
    logic  k_init;
    logic  par_issue;
    logic  par_raw;
    logic  par_val;
    logic  k_inc;
    logic  mul_step;
    logic  exec;
    logic  out_load;
    kind_e out_kind;
  } ic_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic dec_last;
    logic word_neg;
    logic op_bad;
    logic ip_over;
    logic no_params;
    logic par_err;
    logic par_fetch_val;
    logic par_last;
    logic is_mul;
    logic is_in;
    logic is_out;
    logic is_jmp;
    logic is_halt;
    logic jmp_taken;
    logic jmp_bad;
    logic mul_last;
    logic halted;
    logic consumed;
    logic step_lim;
  } ic_stat_t;

  // shift four bits into a remainder modulo m
  function automatic logic [16:0] mod_nib(logic [16:0] r, logic [3:0] nib, logic [16:0] m);
    logic [17:0] t;
    logic [16:0] acc;
    acc = r;
    for (int i = 3; i >= 0; i--) begin
      t = {acc, nib[i]};
      if (t >= {1'b0, m}) t = t - {1'b0, m};
      acc = t[16:0];
    end
    return acc;
  endfunction

  // leading decimal digit of x, x below ten units
  function automatic logic [3:0] hi_digit(logic [16:0] x, logic [16:0] unit);
    logic [3:0] d;
    d = '0;
    for (int k = 1; k < 10; k++) begin
      if (x >= 17'(k) * unit) d = d + 4'd1;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

### hdl/ic_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ic_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ic_ram #(
  parameter  int Width  = 64,
  parameter  int Depth  = 4096,
  localparam int AddrW  = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### hdl/ic_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ic_datapath - intcode datapath
// Architectural registers, serial decimal decoder, operand resolution,
// 32x32 multiply unit, ALU, memory port muxing and the result register.
// ----------------------------------------------------------------------------
module ic_datapath import ic_pkg::*; #(
  parameter  int unsigned MemWords = MemWordsDef,
  localparam int          AddrW    = $clog2(MemWords)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ic_cmd_t            cmd_i,
  output ic_stat_t                stat_o,
  input  wire logic        [11:0] load_address_i,
  input  wire logic signed [63:0] data_value_i,
  input  wire logic        [63:0] ram_rdata_i,
  output logic                    ram_we_o,
  output logic        [AddrW-1:0] ram_waddr_o,
  output logic             [63:0] ram_wdata_o,
  output logic        [AddrW-1:0] ram_raddr_o,
  output logic              [2:0] event_kind_o,
  output logic signed      [63:0] result_value_o
);

  localparam logic [63:0]      MemLimit = 64'(MemWords);
  localparam logic [AddrW:0]   IpLimit  = (AddrW+1)'(MemWords);
  localparam logic [AddrW-1:0] ClrLast  = AddrW'(MemWords - 1);

  logic [AddrW-1:0]   clr_q, clr_d;
  logic [AddrW:0]     ip_q, ip_d;
  logic [63:0]        rb_q, rb_d;
  logic               halted_q, halted_d;
  logic [63:0]        last_q, last_d;
  logic [63:0]        inval_q, inval_d;
  logic               consumed_q, consumed_d;
  logic [StepW-1:0]   steps_q, steps_d;
  logic [63:0]        word_q, word_d;
  logic               sign_q, sign_d;
  logic [DecCntW-1:0] dec_cnt_q, dec_cnt_d;
  logic [6:0]         r100_q, r100_d;
  logic [9:0]         r1k_q, r1k_d;
  logic [13:0]        r10k_q, r10k_d;
  logic [16:0]        r100k_q, r100k_d;
  logic [1:0]         k_q, k_d;
  logic [63:0]        a_q, a_d;
  logic [63:0]        b_q, b_d;
  logic [AddrW-1:0]   dst_q, dst_d;
  logic [63:0]        acc_q, acc_d;
  logic [1:0]         mul_cnt_q, mul_cnt_d;
  kind_e              out_kind_q, out_kind_d;
  logic [63:0]        out_value_q, out_value_d;

  logic [3:0]   m1, m2, m3, mode_k;
  logic [1:0]   n;
  logic         op_ok, is_alu3, wr_k, eff_ok, load_ok, taken;
  logic [AddrW:0] ip_plus_n;
  logic [63:0]  eff, alu_res, prod;
  logic [31:0]  mul_x, mul_y;

  assign m1 = hi_digit(17'(r1k_q), Mod100);
  assign m2 = hi_digit(17'(r10k_q), Mod1k);
  assign m3 = hi_digit(r100k_q, Mod10k);

  always_comb begin
    op_ok = 1'b1;
    unique case (r100_q)
      OpAdd, OpMul, OpLt, OpEq: n = 2'd3;
      OpJnz, OpJz:              n = 2'd2;
      OpIn, OpOut, OpArb:       n = 2'd1;
      OpHalt:                   n = 2'd0;
      default: begin
        n     = 2'd0;
        op_ok = 1'b0;
      end
    endcase
  end

  assign is_alu3   = (r100_q == OpAdd) || (r100_q == OpMul) ||
                     (r100_q == OpLt) || (r100_q == OpEq);
  assign ip_plus_n = ip_q + (AddrW+1)'(n);
  assign wr_k      = (is_alu3 && (k_q == 2'd3)) || ((r100_q == OpIn) && (k_q == 2'd1));

  always_comb begin
    unique case (k_q)
      2'd1:    mode_k = m1;
      2'd2:    mode_k = m2;
      default: mode_k = m3;
    endcase
  end

  assign eff    = (mode_k == ModeRel) ? ram_rdata_i + rb_q : ram_rdata_i;
  assign eff_ok = eff < MemLimit;
  assign taken  = (r100_q == OpJnz) == (a_q != 64'd0);

  assign mul_x = (mul_cnt_q == 2'd2) ? a_q[63:32] : a_q[31:0];
  assign mul_y = (mul_cnt_q == 2'd1) ? b_q[63:32] : b_q[31:0];
  assign prod  = 64'(mul_x) * 64'(mul_y);

  always_comb begin
    unique case (r100_q)
      OpAdd:   alu_res = a_q + b_q;
      OpMul:   alu_res = acc_q;
      OpLt:    alu_res = {63'd0, $signed(a_q) < $signed(b_q)};
      OpEq:    alu_res = {63'd0, a_q == b_q};
      default: alu_res = '0;
    endcase
  end

  assign load_ok = {20'd0, load_address_i} < 32'(MemWords);

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = dst_q;
    ram_wdata_o = alu_res;
    priority if (cmd_i.clr_step) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = clr_q;
      ram_wdata_o = '0;
    end else if (cmd_i.load_wr) begin
      ram_we_o    = load_ok;
      ram_waddr_o = AddrW'(load_address_i);
      ram_wdata_o = data_value_i;
    end else if (cmd_i.exec && is_alu3) begin
      ram_we_o    = 1'b1;
    end else if (cmd_i.exec && (r100_q == OpIn)) begin
      ram_we_o    = 1'b1;
      ram_wdata_o = inval_q;
    end
  end

  always_comb begin
    priority if (cmd_i.fetch)     ram_raddr_o = ip_q[AddrW-1:0];
    else if (cmd_i.par_issue)     ram_raddr_o = ip_q[AddrW-1:0] + AddrW'(k_q);
    else                          ram_raddr_o = eff[AddrW-1:0];
  end

  always_comb begin
    clr_d       = clr_q;
    ip_d        = ip_q;
    rb_d        = rb_q;
    halted_d    = halted_q;
    last_d      = last_q;
    inval_d     = inval_q;
    consumed_d  = consumed_q;
    steps_d     = steps_q;
    word_d      = word_q;
    sign_d      = sign_q;
    dec_cnt_d   = dec_cnt_q;
    r100_d      = r100_q;
    r1k_d       = r1k_q;
    r10k_d      = r10k_q;
    r100k_d     = r100k_q;
    k_d         = k_q;
    a_d         = a_q;
    b_d         = b_q;
    dst_d       = dst_q;
    acc_d       = acc_q;
    mul_cnt_d   = mul_cnt_q;
    out_kind_d  = out_kind_q;
    out_value_d = out_value_q;

    if (cmd_i.clr_step) clr_d = clr_q + AddrW'(1);
    if (cmd_i.run_start) begin
      inval_d    = data_value_i;
      consumed_d = 1'b0;
      steps_d    = '0;
    end
    if (cmd_i.fetch) steps_d = steps_q + StepW'(1);
    if (cmd_i.dec_start) begin
      word_d    = ram_rdata_i;
      sign_d    = ram_rdata_i[63];
      dec_cnt_d = '0;
      r100_d    = '0;
      r1k_d     = '0;
      r10k_d    = '0;
      r100k_d   = '0;
    end
    if (cmd_i.dec_step) begin
      word_d    = {word_q[59:0], 4'd0};
      dec_cnt_d = dec_cnt_q + DecCntW'(1);
      r100_d    = 7'(mod_nib(17'(r100_q), word_q[63:60], Mod100));
      r1k_d     = 10'(mod_nib(17'(r1k_q), word_q[63:60], Mod1k));
      r10k_d    = 14'(mod_nib(17'(r10k_q), word_q[63:60], Mod10k));
      r100k_d   = mod_nib(r100k_q, word_q[63:60], Mod100k);
    end
    if (cmd_i.k_init) begin
      k_d       = 2'd1;
      mul_cnt_d = '0;
    end
    if (cmd_i.k_inc) k_d = k_q + 2'd1;
    if (cmd_i.par_raw) begin
      if (wr_k) begin
        dst_d = eff[AddrW-1:0];
      end else if (mode_k == ModeImm) begin
        if (k_q == 2'd1) a_d = ram_rdata_i;
        else             b_d = ram_rdata_i;
      end
    end
    if (cmd_i.par_val) begin
      if (k_q == 2'd1) a_d = ram_rdata_i;
      else             b_d = ram_rdata_i;
    end
    if (cmd_i.mul_step) begin
      mul_cnt_d = mul_cnt_q + 2'd1;
      if (mul_cnt_q == 2'd0) acc_d = prod;
      else                   acc_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
    end
    if (cmd_i.exec) begin
      unique case (r100_q)
        OpAdd, OpMul, OpLt, OpEq: ip_d = ip_q + (AddrW+1)'(4);
        OpIn: begin
          consumed_d = 1'b1;
          ip_d       = ip_q + (AddrW+1)'(2);
        end
        OpOut: begin
          last_d = a_q;
          ip_d   = ip_q + (AddrW+1)'(2);
        end
        OpJnz, OpJz: ip_d = taken ? {1'b0, b_q[AddrW-1:0]} : ip_q + (AddrW+1)'(3);
        OpArb: begin
          rb_d = rb_q + a_q;
          ip_d = ip_q + (AddrW+1)'(2);
        end
        OpHalt:  halted_d = 1'b1;
        default: ip_d = ip_q;
      endcase
    end
    if (cmd_i.out_load) begin
      out_kind_d = cmd_i.out_kind;
      unique case (cmd_i.out_kind)
        KIND_OUT:  out_value_d = a_q;
        KIND_HALT: out_value_d = last_q;
        default:   out_value_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      ip_q       <= '0;
      rb_q       <= '0;
      halted_q   <= 1'b0;
      last_q     <= '0;
      consumed_q <= 1'b0;
      steps_q    <= '0;
      dec_cnt_q  <= '0;
      k_q        <= '0;
      mul_cnt_q  <= '0;
    end else begin
      clr_q      <= clr_d;
      ip_q       <= ip_d;
      rb_q       <= rb_d;
      halted_q   <= halted_d;
      last_q     <= last_d;
      consumed_q <= consumed_d;
      steps_q    <= steps_d;
      dec_cnt_q  <= dec_cnt_d;
      k_q        <= k_d;
      mul_cnt_q  <= mul_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inval_q     <= inval_d;
    word_q      <= word_d;
    sign_q      <= sign_d;
    r100_q      <= r100_d;
    r1k_q       <= r1k_d;
    r10k_q      <= r10k_d;
    r100k_q     <= r100k_d;
    a_q         <= a_d;
    b_q         <= b_d;
    dst_q       <= dst_d;
    acc_q       <= acc_d;
    out_kind_q  <= out_kind_d;
    out_value_q <= out_value_d;
  end

  always_comb begin
    stat_o.clr_last      = clr_q == ClrLast;
    stat_o.dec_last      = dec_cnt_q == DecCntW'(DecSteps - 1);
    stat_o.word_neg      = sign_q;
    stat_o.op_bad        = !op_ok;
    stat_o.ip_over       = ip_plus_n >= IpLimit;
    stat_o.no_params     = n == 2'd0;
    stat_o.par_err       = wr_k ? (((mode_k != ModePos) && (mode_k != ModeRel)) || !eff_ok)
                                : ((mode_k > ModeRel) || ((mode_k != ModeImm) && !eff_ok));
    stat_o.par_fetch_val = !wr_k && (mode_k != ModeImm);
    stat_o.par_last      = k_q == n;
    stat_o.is_mul        = r100_q == OpMul;
    stat_o.is_in         = r100_q == OpIn;
    stat_o.is_out        = r100_q == OpOut;
    stat_o.is_jmp        = (r100_q == OpJnz) || (r100_q == OpJz);
    stat_o.is_halt       = r100_q == OpHalt;
    stat_o.jmp_taken     = taken;
    stat_o.jmp_bad       = b_q >= MemLimit;
    stat_o.mul_last      = mul_cnt_q == 2'd2;
    stat_o.halted        = halted_q;
    stat_o.consumed      = consumed_q;
    stat_o.step_lim      = steps_q == StepW'(StepLimit);
  end

  assign event_kind_o   = out_kind_q;
  assign result_value_o = out_value_q;

endmodule
`default_nettype wire

### hdl/ic_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ic_ctrl - intcode controller
// Sequences memory clear, word loads and instruction execution, and owns
// the input and output handshakes.
// ----------------------------------------------------------------------------
module ic_ctrl import ic_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     func_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire ic_stat_t stat_i,
  output ic_cmd_t       cmd_o
);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_STEP   = 12'b0000_0000_0100,
    S_LATCH  = 12'b0000_0000_1000,
    S_DECODE = 12'b0000_0001_0000,
    S_CHECK  = 12'b0000_0010_0000,
    S_PISSUE = 12'b0000_0100_0000,
    S_PRAW   = 12'b0000_1000_0000,
    S_PVAL   = 12'b0001_0000_0000,
    S_MUL    = 12'b0010_0000_0000,
    S_EXEC   = 12'b0100_0000_0000,
    S_FINISH = 12'b1000_0000_0000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  kind_e       kind_q, kind_d;
  logic        out_valid_q, out_valid_d;
  ctrl_state_e post_st;

  assign post_st = stat_i.is_mul ? S_MUL : S_EXEC;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.out_kind = kind_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_FINISH;
          if (!func_i) begin
            cmd_o.load_wr = 1'b1;
            kind_d        = KIND_LOAD;
          end else if (stat_i.halted) begin
            kind_d = KIND_HALT;
          end else begin
            cmd_o.run_start = 1'b1;
            state_d         = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (stat_i.step_lim) begin
          kind_d  = KIND_ERR;
          state_d = S_FINISH;
        end else begin
          cmd_o.fetch = 1'b1;
          state_d     = S_LATCH;
        end
      end
      S_LATCH: begin
        cmd_o.dec_start = 1'b1;
        state_d         = S_DECODE;
      end
      S_DECODE: begin
        cmd_o.dec_step = 1'b1;
        if (stat_i.dec_last) state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.k_init = 1'b1;
        if (stat_i.word_neg || stat_i.op_bad || stat_i.ip_over) begin
          kind_d  = KIND_ERR;
          state_d = S_FINISH;
        end else if (stat_i.no_params) begin
          state_d = S_EXEC;
        end else begin
          state_d = S_PISSUE;
        end
      end
      S_PISSUE: begin
        cmd_o.par_issue = 1'b1;
        state_d         = S_PRAW;
      end
      S_PRAW: begin
        cmd_o.par_raw = 1'b1;
        priority if (stat_i.par_err) begin
          kind_d  = KIND_ERR;
          state_d = S_FINISH;
        end else if (stat_i.par_fetch_val) begin
          state_d = S_PVAL;
        end else if (stat_i.par_last) begin
          state_d = post_st;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = S_PISSUE;
        end
      end
      S_PVAL: begin
        cmd_o.par_val = 1'b1;
        if (stat_i.par_last) begin
          state_d = post_st;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = S_PISSUE;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.mul_last) state_d = S_EXEC;
      end
      S_EXEC: begin
        priority if (stat_i.is_in && stat_i.consumed) begin
          kind_d  = KIND_NEED;
          state_d = S_FINISH;
        end else if (stat_i.is_jmp && stat_i.jmp_taken && stat_i.jmp_bad) begin
          kind_d  = KIND_ERR;
          state_d = S_FINISH;
        end else begin
          cmd_o.exec = 1'b1;
          priority if (stat_i.is_out) begin
            kind_d  = KIND_OUT;
            state_d = S_FINISH;
          end else if (stat_i.is_halt) begin
            kind_d  = KIND_HALT;
            state_d = S_FINISH;
          end else begin
            state_d = S_STEP;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load)              out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      kind_q      <= KIND_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### hdl/intcode_processor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// intcode_processor - decimal-coded processor with 64-bit signed words
// Loads program words and runs the program one input word at a time.
// ----------------------------------------------------------------------------
// After reset the word memory is cleared, one word a cycle; in_stall_o
// stays high until that pass is done. A load word goes to the finish state,
// which loads its result into the output register once that register is
// free, then returns to idle for the next word. A run word executes
// instructions until an output, a second input request, a halt or an error;
// each instruction goes through fetch, serial decimal decode (4 bits a cycle),
// a check state, an issue and a raw read per parameter plus a value read for
// a memory operand through the single read port, partial-product steps on the
// shared 32x32 multiplier for a multiply, and an execute state. The finished
// result sits in an output register while the next word is accepted.
// ----------------------------------------------------------------------------
module intcode_processor import ic_pkg::*; #(
  parameter int unsigned MemWords = MemWordsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               func_i,
  input  wire logic        [11:0] load_address_i,
  input  wire logic signed [63:0] data_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic              [2:0] event_kind_o,
  output logic signed      [63:0] result_value_o
);

  localparam int AddrW = $clog2(MemWords);

  ic_cmd_t          cmd;
  ic_stat_t         stat;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [63:0]      ram_wdata, ram_rdata;

  ic_ram #(
    .Width (64),
    .Depth (MemWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ic_datapath #(
    .MemWords (MemWords)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .load_address_i (load_address_i),
    .data_value_i   (data_value_i),
    .ram_rdata_i    (ram_rdata),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .event_kind_o   (event_kind_o),
    .result_value_o (result_value_o)
  );

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != KIND_OUT) && (event_kind_o != KIND_HALT)
    |-> result_value_o == '0)
    else $error("nonzero value on a result without one");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("word accepted while previous one still in work");

  a_load_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised while idle");

endmodule
`default_nettype wire
